@@ src/lc3c_pkg.sv @@
// ----------------------------------------------------------------------------
// lc3c_pkg
// Shared widths, types and the boundary test step of the 3D line clipper.
// ----------------------------------------------------------------------------
package lc3c_pkg;

  localparam int FRAC_BITS = 16;
  localparam int T_FRAC    = 28;
  localparam int CW        = 32;
  localparam int DW        = 33;
  localparam int MW        = 33;
  localparam int QB        = 30;
  localparam int TW        = 30;
  localparam int TU        = T_FRAC + 1;
  localparam int RW        = 64;
  localparam int STEP_PER  = 2;
  localparam int DIV_ST    = QB / STEP_PER;
  localparam int NLANE     = 6;

  localparam logic [QB-1:0]        T_ONE_Q  = QB'(64'd1 << T_FRAC);
  localparam logic signed [TW-1:0] T_ONE_T  = TW'(64'd1 << T_FRAC);
  localparam logic [TU-1:0]        T_ONE_U  = TU'(64'd1 << T_FRAC);
  localparam logic signed [33:0]   CUBE_ONE = 34'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic [2:0][CW-1:0] st;
    logic [2:0][CW-1:0] ed;
    logic [2:0][DW-1:0] d;
    logic [23:0]        c0;
    logic [23:0]        c1;
    logic [NLANE-1:0]   dz;
    logic [NLANE-1:0]   dp;
    logic [NLANE-1:0]   np;
    logic [NLANE-1:0]   ng;
  } side_t;

  typedef struct packed {
    logic signed [TW-1:0] te;
    logic signed [TW-1:0] tl;
    logic                 vis;
  } clip_win_t;

  function automatic logic [MW-1:0] abs34(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = v[33] ? -v : v;
    return a[MW-1:0];
  endfunction

  function automatic clip_win_t edge_step(input clip_win_t w, input logic dz,
                                          input logic dp, input logic np,
                                          input logic signed [TW-1:0] t);
    clip_win_t r;
    r = w;
    if (w.vis) begin
      if (dz) begin
        r.vis = !np;
      end else if (dp) begin
        if (t > w.tl) r.vis = 1'b0;
        else if (t > w.te) r.te = t;
      end else begin
        if (t < w.te) r.vis = 1'b0;
        else if (t < w.tl) r.tl = t;
      end
    end
    return r;
  endfunction

endpackage

@@ src/lc3c_seg_if.sv @@
// ----------------------------------------------------------------------------
// lc3c_seg_if
// Input channel: one line segment with two endpoint colors per word.
// ----------------------------------------------------------------------------
interface lc3c_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic [23:0]        start_color;
  logic [23:0]        end_color;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  start_color, end_color, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                start_color, end_color, output ready);
endinterface

@@ src/lc3c_clip_if.sv @@
// ----------------------------------------------------------------------------
// lc3c_clip_if
// Output channel: one clipped segment with interpolated colors per word.
// ----------------------------------------------------------------------------
interface lc3c_clip_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] clip_start_x;
  logic signed [31:0] clip_start_y;
  logic signed [31:0] clip_start_z;
  logic signed [31:0] clip_end_x;
  logic signed [31:0] clip_end_y;
  logic signed [31:0] clip_end_z;
  logic [23:0]        clip_start_color;
  logic [23:0]        clip_end_color;

  modport source (output valid, visible, clip_start_x, clip_start_y, clip_start_z,
                  clip_end_x, clip_end_y, clip_end_z, clip_start_color,
                  clip_end_color, input ready);
  modport sink (input valid, visible, clip_start_x, clip_start_y, clip_start_z,
                clip_end_x, clip_end_y, clip_end_z, clip_start_color,
                clip_end_color, output ready);
endinterface

@@ src/lc3c_div.sv @@
// ----------------------------------------------------------------------------
// lc3c_div
// Pipelined restoring divider: floor(num * 2^28 / den), two quotient bits per
// stage, with a flag for quotients of four or more.
// ----------------------------------------------------------------------------
module lc3c_div (
  input  logic                         clk,
  input  logic [lc3c_pkg::DIV_ST-1:0]  en,
  input  logic [lc3c_pkg::MW-1:0]      num,
  input  logic [lc3c_pkg::MW-1:0]      den,
  output logic [lc3c_pkg::QB-1:0]      q,
  output logic                         ovf
);
  import lc3c_pkg::*;

  logic [RW-1:0] r   [DIV_ST-1];
  logic [MW-1:0] dv  [DIV_ST-1];
  logic [QB-1:0] qr  [DIV_ST];
  logic          ov  [DIV_ST];

  for (genvar j = 0; j < DIV_ST; j++) begin : g_st
    logic [RW-1:0] r_src, r_nxt;
    logic [MW-1:0] d_src;
    logic [QB-1:0] q_src, q_nxt;
    logic          o_src;

    if (j == 0) begin : g_first
      assign r_src = {{(RW-MW-T_FRAC){1'b0}}, num, {T_FRAC{1'b0}}};
      assign d_src = den;
      assign q_src = '0;
      assign o_src = ({2'b00, num} >= {den, 2'b00});
    end else begin : g_next
      assign r_src = r[j-1];
      assign d_src = dv[j-1];
      assign q_src = qr[j-1];
      assign o_src = ov[j-1];
    end

    always_comb begin
      logic [RW-1:0] trial;
      r_nxt = r_src;
      q_nxt = q_src;
      for (int s = 0; s < STEP_PER; s++) begin
        trial = {{(RW-MW){1'b0}}, d_src} << (QB - 1 - (j * STEP_PER + s));
        if (r_nxt >= trial) begin
          r_nxt = r_nxt - trial;
          q_nxt[QB - 1 - (j * STEP_PER + s)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        qr[j] <= q_nxt;
        ov[j] <= o_src;
      end
    end

    if (j < DIV_ST - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[j]) begin
          r[j]  <= r_nxt;
          dv[j] <= d_src;
        end
      end
    end
  end

  assign q   = qr[DIV_ST-1];
  assign ovf = ov[DIV_ST-1];

endmodule

@@ src/line_clip_3d_color_core.sv @@
// ----------------------------------------------------------------------------
// line_clip_3d_color_core
// Clips a 3D segment against the unit cube and interpolates its colors.
// ----------------------------------------------------------------------------
// Segments enter on the seg channel, one word per segment: two Q16.16
// endpoints and two RGB888 colors. Each result leaves on the clip channel
// as one word: a visible flag, the clipped endpoints and the colors at the
// entry and exit parameters. A rejected segment comes back unchanged with
// visible low.
// The pipeline has 20 register stages. One segment can enter in every cycle
// while the receiver does not stall. The stages are an input stage for the
// differences, then the six dividers, which take two quotient bits per stage
// over fifteen stages, followed by two boundary test stages, a multiply stage
// and an add stage that is also the output register.
// Each stage holds its word while the next one is full and stalled, so a
// receiver stall fills empty stages first and only then lowers seg.ready.
// Nothing is lost or repeated. Reset clears every valid bit.
// ----------------------------------------------------------------------------
module line_clip_3d_color_core (
  input logic  clk,
  input logic  rst,
  lc3c_seg_if.sink    seg,
  lc3c_clip_if.source clip
);
  import lc3c_pkg::*;

  localparam int NST  = DIV_ST + 5;
  localparam int SE1  = DIV_ST + 1;
  localparam int SE2  = DIV_ST + 2;
  localparam int SM   = DIV_ST + 3;
  localparam int SA   = DIV_ST + 4;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  assign rdy[NST] = clip.ready;
  for (genvar k = 0; k < NST; k++) begin : g_hs
    assign rdy[k] = !v[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= (k == 0) ? seg.valid : v[(k == 0) ? 0 : k-1];
      end
    end
  end
  assign seg.ready = rdy[0];

  // Stage 0: differences, numerators, denominators and their signs.
  side_t          sd_in, sd0;
  logic [MW-1:0]  nm_in [NLANE];
  logic [MW-1:0]  dn_in [NLANE];
  logic [MW-1:0]  nm0   [NLANE];
  logic [MW-1:0]  dn0   [NLANE];
  logic [CW-1:0]  st_w  [3];
  logic [CW-1:0]  ed_w  [3];

  assign st_w[0] = seg.start_x;
  assign st_w[1] = seg.start_y;
  assign st_w[2] = seg.start_z;
  assign ed_w[0] = seg.end_x;
  assign ed_w[1] = seg.end_y;
  assign ed_w[2] = seg.end_z;

  always_comb begin
    logic signed [33:0] p, e, dd, na, nb, db;
    sd_in    = '0;
    sd_in.c0 = seg.start_color;
    sd_in.c1 = seg.end_color;
    for (int i = 0; i < 3; i++) begin
      p  = {{2{st_w[i][CW-1]}}, st_w[i]};
      e  = {{2{ed_w[i][CW-1]}}, ed_w[i]};
      dd = e - p;
      na = -CUBE_ONE - p;
      nb = p - CUBE_ONE;
      db = -dd;
      sd_in.st[i] = st_w[i];
      sd_in.ed[i] = ed_w[i];
      sd_in.d[i]  = dd[DW-1:0];
      sd_in.dz[2*i]   = (dd == 34'sd0);
      sd_in.dz[2*i+1] = (dd == 34'sd0);
      sd_in.dp[2*i]   = !dd[33] && (dd != 34'sd0);
      sd_in.dp[2*i+1] = dd[33];
      sd_in.np[2*i]   = !na[33] && (na != 34'sd0);
      sd_in.np[2*i+1] = !nb[33] && (nb != 34'sd0);
      sd_in.ng[2*i]   = na[33] ^ dd[33];
      sd_in.ng[2*i+1] = nb[33] ^ db[33];
      nm_in[2*i]   = abs34(na);
      nm_in[2*i+1] = abs34(nb);
      dn_in[2*i]   = abs34(dd);
      dn_in[2*i+1] = abs34(db);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sd0 <= sd_in;
      nm0 <= nm_in;
      dn0 <= dn_in;
    end
  end

  // Stages 1 to DIV_ST: the six candidate parameters.
  logic [QB-1:0] dq  [NLANE];
  logic          dov [NLANE];
  side_t         sdd [DIV_ST];

  for (genvar l = 0; l < NLANE; l++) begin : g_div
    lc3c_div u_div (
      .clk (clk),
      .en  (rdy[DIV_ST:1]),
      .num (nm0[l]),
      .den (dn0[l]),
      .q   (dq[l]),
      .ovf (dov[l])
    );
  end

  for (genvar j = 0; j < DIV_ST; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[j+1]) sdd[j] <= (j == 0) ? sd0 : sdd[(j == 0) ? 0 : j-1];
    end
  end

  // Boundary tests: three in each of two stages.
  logic signed [TW-1:0] t_in [NLANE];
  logic signed [TW-1:0] t1   [NLANE];
  side_t                sd1, sd2;
  clip_win_t            w1_in, w1, w2_in, w2;

  always_comb begin
    logic [QB-1:0] qs;
    for (int l = 0; l < NLANE; l++) begin
      qs = (dov[l] || dq[l] > T_ONE_Q) ? T_ONE_Q + QB'(1) : dq[l];
      t_in[l] = sdd[DIV_ST-1].ng[l] ? -$signed(qs) : $signed(qs);
    end
    w1_in.te  = '0;
    w1_in.tl  = T_ONE_T;
    w1_in.vis = 1'b1;
    for (int l = 0; l < 3; l++) begin
      w1_in = edge_step(w1_in, sdd[DIV_ST-1].dz[l], sdd[DIV_ST-1].dp[l],
                        sdd[DIV_ST-1].np[l], t_in[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[SE1]) begin
      sd1 <= sdd[DIV_ST-1];
      t1  <= t_in;
      w1  <= w1_in;
    end
  end

  always_comb begin
    w2_in = w1;
    for (int l = 3; l < NLANE; l++) begin
      w2_in = edge_step(w2_in, sd1.dz[l], sd1.dp[l], sd1.np[l], t1[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[SE2]) begin
      sd2 <= sd1;
      w2  <= w2_in;
    end
  end

  // Multiply stage.
  side_t                   sdm;
  logic                    vm;
  logic [MW+TU-1:0]        ps   [3];
  logic [MW+TU-1:0]        pe   [3];
  logic [8+TU-1:0]         ca_s [3];
  logic [8+TU-1:0]         cb_s [3];
  logic [8+TU-1:0]         ca_e [3];
  logic [8+TU-1:0]         cb_e [3];

  always_ff @(posedge clk) begin
    logic [TU-1:0] teu, tlu;
    logic [MW-1:0] md;
    if (rdy[SM]) begin
      teu = w2.te[TU-1:0];
      tlu = w2.tl[TU-1:0];
      sdm <= sd2;
      vm  <= w2.vis;
      for (int i = 0; i < 3; i++) begin
        md = abs34({sd2.d[i][DW-1], sd2.d[i]});
        ps[i]   <= md * teu;
        pe[i]   <= md * tlu;
        ca_s[i] <= sd2.c0[8*i +: 8] * (T_ONE_U - teu);
        cb_s[i] <= sd2.c1[8*i +: 8] * teu;
        ca_e[i] <= sd2.c0[8*i +: 8] * (T_ONE_U - tlu);
        cb_e[i] <= sd2.c1[8*i +: 8] * tlu;
      end
    end
  end

  // Add stage and output register.
  logic           o_vis;
  logic [CW-1:0]  o_st [3];
  logic [CW-1:0]  o_ed [3];
  logic [23:0]    o_cs, o_ce;

  always_ff @(posedge clk) begin
    logic [33:0] p, ss, se;
    logic [9+TU-1:0] sum_s, sum_e;
    if (rdy[SA]) begin
      o_vis <= vm;
      for (int i = 0; i < 3; i++) begin
        p  = {{2{sdm.st[i][CW-1]}}, sdm.st[i]};
        ss = ps[i][MW+TU-1:T_FRAC];
        se = pe[i][MW+TU-1:T_FRAC];
        if (!vm) begin
          o_st[i] <= sdm.st[i];
          o_ed[i] <= sdm.ed[i];
        end else if (sdm.d[i][DW-1]) begin
          o_st[i] <= CW'(p - ss);
          o_ed[i] <= CW'(p - se);
        end else begin
          o_st[i] <= CW'(p + ss);
          o_ed[i] <= CW'(p + se);
        end
        sum_s = {1'b0, ca_s[i]} + {1'b0, cb_s[i]};
        sum_e = {1'b0, ca_e[i]} + {1'b0, cb_e[i]};
        o_cs[8*i +: 8] <= vm ? sum_s[T_FRAC +: 8] : sdm.c0[8*i +: 8];
        o_ce[8*i +: 8] <= vm ? sum_e[T_FRAC +: 8] : sdm.c1[8*i +: 8];
      end
    end
  end

  assign clip.valid            = v[SA];
  assign clip.visible          = o_vis;
  assign clip.clip_start_x     = o_st[0];
  assign clip.clip_start_y     = o_st[1];
  assign clip.clip_start_z     = o_st[2];
  assign clip.clip_end_x       = o_ed[0];
  assign clip.clip_end_y       = o_ed[1];
  assign clip.clip_end_z       = o_ed[2];
  assign clip.clip_start_color = o_cs;
  assign clip.clip_end_color   = o_ce;

endmodule

@@ verif/tb_line_clip_3d_color_core.sv @@
// ----------------------------------------------------------------------------
// tb_line_clip_3d_color_core
// Self-checking testbench for the 3D line clipper with color interpolation.
// ----------------------------------------------------------------------------
// Segments are queued by an initial block and driven by a clocked driver
// with random idle bursts. A clocked monitor with random stalls compares
// every clipped word with a prediction computed from the Liang-Barsky
// parameter test. One long receiver stall fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_line_clip_3d_color_core;
  import lc3c_pkg::*;

  localparam int LATENCY = 20;
  localparam int RAND_SEGS = 1600;
  localparam longint T_UNIT = 64'sd1 << T_FRAC;
  localparam longint Q_ONE = 64'sd1 << FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [23:0]        c0, c1;
  } segment_t;

  typedef struct packed {
    logic               vis;
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [23:0]        c0, c1;
  } clipped_t;

  logic clk;
  logic rst;

  lc3c_seg_if  seg();
  lc3c_clip_if clip();

  line_clip_3d_color_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .seg  (seg.sink),
    .clip (clip.source)
  );

  segment_t segs_pending[$];
  clipped_t clips_expected[$];
  int       errors;
  int       sent;
  int       received;
  int       visible_count;
  int       idle_left;
  int       stall_left;
  int       hold_cycles;
  bit       calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Quantized candidate parameter num/den, truncated toward zero, saturated.
  function automatic longint param_of(input longint den, input longint num);
    longint unsigned mn, md, q;
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (mn << T_FRAC) / md;
    if (q > T_UNIT) q = T_UNIT + 1;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit boundary(input longint den, input longint num,
                                  inout longint te, inout longint tl);
    longint t;
    if (den == 0) return num <= 0;
    t = param_of(den, num);
    if (den > 0) begin
      if (t > tl) return 0;
      if (t > te) te = t;
    end else begin
      if (t < te) return 0;
      if (t < tl) tl = t;
    end
    return 1;
  endfunction

  function automatic logic [31:0] point_at(input longint p, input longint d,
                                           input longint t);
    longint unsigned md, step;
    md = d < 0 ? -d : d;
    step = (md * t) >> T_FRAC;
    return d < 0 ? 32'(p - longint'(step)) : 32'(p + longint'(step));
  endfunction

  function automatic logic [23:0] color_at(input logic [23:0] a, input logic [23:0] b,
                                           input longint t);
    logic [23:0] r;
    longint unsigned v;
    for (int k = 0; k < 3; k++) begin
      v = (longint'(a[8*k +: 8]) * (T_UNIT - t) + longint'(b[8*k +: 8]) * t) >> T_FRAC;
      r[8*k +: 8] = v[7:0];
    end
    return r;
  endfunction

  function automatic clipped_t clip_segment(input segment_t s);
    clipped_t r;
    longint p[3], d[3], te, tl;
    bit vis;
    p[0] = s.sx; p[1] = s.sy; p[2] = s.sz;
    d[0] = longint'(s.ex) - p[0];
    d[1] = longint'(s.ey) - p[1];
    d[2] = longint'(s.ez) - p[2];
    te = 0;
    tl = T_UNIT;
    vis = 1;
    for (int k = 0; k < 3 && vis; k++) begin
      vis = boundary(d[k], -Q_ONE - p[k], te, tl);
      if (vis) vis = boundary(-d[k], p[k] - Q_ONE, te, tl);
    end
    if (!vis) begin
      r = '{1'b0, s.sx, s.sy, s.sz, s.ex, s.ey, s.ez, s.c0, s.c1};
    end else begin
      r.vis = 1'b1;
      r.sx = point_at(p[0], d[0], te);
      r.sy = point_at(p[1], d[1], te);
      r.sz = point_at(p[2], d[2], te);
      r.ex = point_at(p[0], d[0], tl);
      r.ey = point_at(p[1], d[1], tl);
      r.ez = point_at(p[2], d[2], tl);
      r.c0 = color_at(s.c0, s.c1, te);
      r.c1 = color_at(s.c0, s.c1, tl);
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("Mismatch in word %0d, %s: got %h, expected %h", received, what, got, want);
  endtask

  function automatic logic [31:0] coord_pick();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0001_0000;
      3: return 32'hffff_0000;
      4: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000);
    endcase
  endfunction

  task automatic add_segment(input logic [31:0] sx, sy, sz, ex, ey, ez,
                             input logic [23:0] c0, c1);
    segs_pending.insert(segs_pending.size(), '{sx, sy, sz, ex, ey, ez, c0, c1});
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
      idle_left <= 0;
    end else begin
      if (seg.valid && seg.ready) begin
        clips_expected.insert(clips_expected.size(),
                              clip_segment({seg.start_x, seg.start_y, seg.start_z,
                                            seg.end_x, seg.end_y, seg.end_z,
                                            seg.start_color, seg.end_color}));
        sent <= sent + 1;
      end
      if (!seg.valid || seg.ready) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          seg.valid <= 1'b0;
        end else if (segs_pending.size() > 0) begin
          segment_t s;
          s = segs_pending.pop_front();
          seg.valid <= 1'b1;
          {seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z,
           seg.start_color, seg.end_color} <= s;
          if (!calm && $urandom_range(0, 19) == 0) idle_left <= $urandom_range(1, 14);
        end else begin
          seg.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst) begin
      clip.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (clip.valid && clip.ready) begin
        clipped_t g, w;
        g = '{clip.visible, clip.clip_start_x, clip.clip_start_y, clip.clip_start_z,
              clip.clip_end_x, clip.clip_end_y, clip.clip_end_z,
              clip.clip_start_color, clip.clip_end_color};
        if (clips_expected.size() == 0) begin
          errors++;
          $display("Unexpected word %0d from the clipper", received);
        end else begin
          w = clips_expected.pop_front();
          if (g.vis !== w.vis) report("visible", 32'(g.vis), 32'(w.vis));
          if (g.sx !== w.sx) report("clip_start_x", g.sx, w.sx);
          if (g.sy !== w.sy) report("clip_start_y", g.sy, w.sy);
          if (g.sz !== w.sz) report("clip_start_z", g.sz, w.sz);
          if (g.ex !== w.ex) report("clip_end_x", g.ex, w.ex);
          if (g.ey !== w.ey) report("clip_end_y", g.ey, w.ey);
          if (g.ez !== w.ez) report("clip_end_z", g.ez, w.ez);
          if (g.c0 !== w.c0) report("clip_start_color", 32'(g.c0), 32'(w.c0));
          if (g.c1 !== w.c1) report("clip_end_color", 32'(g.c1), 32'(w.c1));
          if (w.vis) visible_count++;
        end
        received++;
      end
      if (hold_cycles > 0) begin
        clip.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        clip.ready <= 1'b0;
      end else begin
        clip.ready <= 1'b1;
        if (!calm && $urandom_range(0, 19) == 0) stall_left <= $urandom_range(1, 14);
      end
    end
  end

  // Long receiver hold-off so that the pipeline fills and stalls its input.
  initial begin
    hold_cycles = 0;
    wait (sent > 300);
    hold_cycles = 1;
    repeat (80) @(posedge clk) hold_cycles++;
    hold_cycles = 0;
  end

  initial begin
    #20_000_000;
    $display("** line_clip_3d_color_core: FAILED **");
    $finish;
  end

  initial begin
    logic [31:0] a, b;
    errors = 0;
    sent = 0;
    received = 0;
    visible_count = 0;
    calm = 0;
    rst = 1'b1;
    seg.valid = 1'b0;
    {seg.start_x, seg.start_y, seg.start_z, seg.end_x, seg.end_y, seg.end_z,
     seg.start_color, seg.end_color} = '0;
    clip.ready = 1'b0;

    add_segment(0, 0, 0, 0, 0, 0, 24'h123456, 24'hfedcba);
    add_segment(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h000000, 24'hffffff);
    add_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 24'hffffff, 24'h000000);
    add_segment(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 24'hff00ff, 24'h00ff00);
    add_segment(32'h0002_0000, 0, 0, 32'h0003_0000, 0, 0, 24'h111111, 24'h222222);
    add_segment(32'h0002_0000, 32'h0002_0000, 0, 32'h0002_0000, 32'h0002_0000,
                0, 24'h1, 24'h2);
    add_segment(0, 0, 32'hfffe_0000, 0, 0, 32'h0002_0000, 24'habcdef, 24'h000001);
    add_segment(32'h0002_0000, 0, 0, 0, 32'h0002_0000, 0, 24'hffffff, 24'hffffff);
    add_segment(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h808080, 24'h7f7f7f);
    add_segment(32'h0001_0001, 0, 0, 32'h0001_0001, 0, 0, 24'h0, 24'h0);
    add_segment(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'hff0000,
                24'h0000ff);
    add_segment(32'hfffd_0000, 32'h0000_8000, 32'h0000_4000, 32'h0003_0000,
                32'hffff_8000, 32'hffff_c000, 24'h00ff00, 24'hff00ff);
    add_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 24'hffffff, 24'hffffff);
    for (int n = 0; n < RAND_SEGS; n++) begin
      a = coord_pick();
      b = coord_pick();
      add_segment(coord_pick(), coord_pick(), a, coord_pick(),
                  coord_pick(), $urandom_range(0, 3) == 0 ? a : b,
                  24'($urandom), 24'($urandom));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (segs_pending.size() < 150);
    calm = 1;
    wait (segs_pending.size() == 0 && !seg.valid);
    wait (clips_expected.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Clipped %0d segments, %0d visible, with idle bursts and a long output stall.",
             received, visible_count);
    if (errors == 0) begin
      $display("** line_clip_3d_color_core: PASSED **");
    end else begin
      $display("** line_clip_3d_color_core: FAILED **");
    end
    $finish;
  end

endmodule
